// ===== design/tlt_pkg.sv =====
// Shared types, token kind codes and character constants for the tape language tokenizer.
package tlt_pkg;

    // Default width of the position and line counters.
    localparam int COUNT_BITS_DEF = 16;

    // Number of per-character entries held in the result queue.
    localparam int RES_DEPTH = 4;

    // Token kinds.
    localparam logic [3:0] KIND_END        = 4'd0;
    localparam logic [3:0] KIND_ERR        = 4'd1;
    localparam logic [3:0] KIND_IDENT      = 4'd2;
    localparam logic [3:0] KIND_IMM        = 4'd3;
    localparam logic [3:0] KIND_VAR        = 4'd4;
    localparam logic [3:0] KIND_PUNCT_BASE = 4'd5;
    localparam logic [3:0] KIND_MAX        = 4'd14;

    // Characters with a special meaning.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_VIS_LO = 8'h20;
    localparam logic [7:0] CH_VIS_HI = 8'h7E;

    // Punctuators in kind order: = > < { } ( ) [ ] ,
    localparam int PUNCT_COUNT = 10;
    localparam logic [7:0] PUNCT_CHARS [PUNCT_COUNT] = '{
        8'h3D, 8'h3E, 8'h3C, 8'h7B, 8'h7D, 8'h28, 8'h29, 8'h5B, 8'h5D, 8'h2C
    };

    typedef struct packed {
        logic       start_new;
        logic [7:0] char_code;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [15:0] token_start;
        logic [15:0] token_length;
        logic [15:0] token_line;
        logic        run_last;
    } out_item_t;

    // Everything one character produces: zero, one or two tokens.
    typedef struct packed {
        logic [1:0] count;
        out_item_t  first;
        out_item_t  second;
    } tok_pair_t;

endpackage

// ===== design/tlt_lexer.sv =====
// Lexer state registers and the per-character mode transition and token logic.
module tlt_lexer #(
    parameter int COUNT_BITS = tlt_pkg::COUNT_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  tlt_pkg::in_item_t  item,
    output tlt_pkg::tok_pair_t pair
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam int EXT_BITS = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    typedef enum logic [3:0] {
        M_IDLE, M_SLASH, M_LINEC, M_BLOCK, M_BSTAR, M_DOLLAR, M_CHVAR,
        M_IDENT, M_QUOTE, M_QX, M_QXH, M_QXHH, M_QVIS
    } mode_t;

    mode_t                 mode_reg, mode_next, mode_e;
    logic [COUNT_BITS-1:0] pos_reg, pos_next, pos_e;
    logic [COUNT_BITS-1:0] line_reg, line_next, line_e;
    logic [COUNT_BITS-1:0] pstart_reg, pstart_next, pstart_e;
    logic [COUNT_BITS-1:0] pline_reg, pline_next, pline_e;
    logic                  fin_reg, fin_next, fin_e;

    logic [7:0]            c;
    logic                  is_letter, is_alnum, is_hex, is_ws;
    logic                  punct_hit;
    logic [3:0]            punct_kind;
    logic                  do_idle, fail;
    logic                  a_vld, b_vld;
    logic [3:0]            a_kind, b_kind;
    logic [COUNT_BITS-1:0] a_len;
    logic                  b_len;
    tlt_pkg::out_item_t    tok_a, tok_b;

    function automatic logic [15:0] sat16(input logic [COUNT_BITS-1:0] v);
        logic [EXT_BITS-1:0] w;
        w = EXT_BITS'(v);
        return (w > EXT_BITS'(16'hFFFF)) ? 16'hFFFF : w[15:0];
    endfunction

    always_comb begin
        // A new start clears everything before the character is looked at.
        mode_e   = mode_reg;
        pos_e    = pos_reg;
        line_e   = line_reg;
        pstart_e = pstart_reg;
        pline_e  = pline_reg;
        fin_e    = fin_reg;
        if (item.start_new) begin
            mode_e   = M_IDLE;
            pos_e    = '0;
            line_e   = COUNT_BITS'(1);
            pstart_e = '0;
            pline_e  = COUNT_BITS'(1);
            fin_e    = 1'b0;
        end

        c         = item.char_code;
        is_letter = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || (c == 8'h5F);
        is_alnum  = is_letter || (c >= 8'h30 && c <= 8'h39);
        is_hex    = (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)
                    || (c >= 8'h30 && c <= 8'h39);
        is_ws     = (c == tlt_pkg::CH_SPACE) || (c == tlt_pkg::CH_TAB) || (c == tlt_pkg::CH_LF);

        punct_hit  = 1'b0;
        punct_kind = tlt_pkg::KIND_PUNCT_BASE;
        for (int i = 0; i < tlt_pkg::PUNCT_COUNT; i++) begin
            if (c == tlt_pkg::PUNCT_CHARS[i]) begin
                punct_hit  = 1'b1;
                punct_kind = tlt_pkg::KIND_PUNCT_BASE + 4'(i);
            end
        end

        mode_next   = mode_e;
        pstart_next = pstart_e;
        pline_next  = pline_e;
        fin_next    = fin_e;
        do_idle     = 1'b0;
        fail        = 1'b0;
        a_vld       = 1'b0;
        a_kind      = tlt_pkg::KIND_ERR;
        a_len       = '0;
        b_vld       = 1'b0;
        b_kind      = tlt_pkg::KIND_ERR;
        b_len       = 1'b0;

        // Token A is the pending token, token B one that starts at this character.
        if (!fin_e) begin
            case (mode_e)
                M_SLASH: begin
                    if (c == tlt_pkg::CH_SLASH) begin
                        mode_next = M_LINEC;
                    end else if (c == tlt_pkg::CH_STAR) begin
                        mode_next = M_BLOCK;
                    end else begin
                        fin_next  = 1'b1;
                        mode_next = M_IDLE;
                        a_vld     = 1'b1;
                        a_kind    = tlt_pkg::KIND_ERR;
                    end
                end
                M_LINEC: begin
                    if (c == tlt_pkg::CH_LF) begin
                        mode_next = M_IDLE;
                    end else if (c == tlt_pkg::CH_NUL) begin
                        do_idle = 1'b1;
                    end
                end
                M_BLOCK, M_BSTAR: begin
                    if (c == tlt_pkg::CH_NUL) begin
                        do_idle = 1'b1;
                    end else if (c == tlt_pkg::CH_STAR) begin
                        mode_next = M_BSTAR;
                    end else if (c == tlt_pkg::CH_SLASH && mode_e == M_BSTAR) begin
                        mode_next = M_IDLE;
                    end else begin
                        mode_next = M_BLOCK;
                    end
                end
                M_DOLLAR: begin
                    if (c == tlt_pkg::CH_DOLLAR) begin
                        mode_next = M_IDLE;
                        a_vld     = 1'b1;
                        a_kind    = tlt_pkg::KIND_VAR;
                        a_len     = COUNT_BITS'(2);
                    end else if (is_letter) begin
                        mode_next = M_CHVAR;
                    end else begin
                        fail = 1'b1;
                    end
                end
                M_CHVAR, M_IDENT: begin
                    if (!is_alnum) begin
                        a_vld   = 1'b1;
                        a_kind  = (mode_e == M_CHVAR) ? tlt_pkg::KIND_VAR : tlt_pkg::KIND_IDENT;
                        a_len   = pos_e - pstart_e;
                        do_idle = 1'b1;
                    end
                end
                M_QUOTE: begin
                    if (c == tlt_pkg::CH_QUOTE) begin
                        fail = 1'b1;
                    end else if (c == tlt_pkg::CH_X) begin
                        mode_next = M_QX;
                    end else if (c >= tlt_pkg::CH_VIS_LO && c <= tlt_pkg::CH_VIS_HI) begin
                        mode_next = M_QVIS;
                    end else begin
                        fail = 1'b1;
                    end
                end
                M_QX: begin
                    if (c == tlt_pkg::CH_QUOTE) begin
                        mode_next = M_IDLE;
                        a_vld     = 1'b1;
                        a_kind    = tlt_pkg::KIND_IMM;
                        a_len     = COUNT_BITS'(3);
                    end else if (is_hex) begin
                        mode_next = M_QXH;
                    end else begin
                        fail = 1'b1;
                    end
                end
                M_QXH: begin
                    if (is_hex) begin
                        mode_next = M_QXHH;
                    end else begin
                        fail = 1'b1;
                    end
                end
                M_QXHH, M_QVIS: begin
                    if (c == tlt_pkg::CH_QUOTE) begin
                        mode_next = M_IDLE;
                        a_vld     = 1'b1;
                        a_kind    = tlt_pkg::KIND_IMM;
                        a_len     = (mode_e == M_QXHH) ? COUNT_BITS'(5) : COUNT_BITS'(3);
                    end else begin
                        fail = 1'b1;
                    end
                end
                default: begin
                    do_idle = 1'b1;
                end
            endcase
        end

        // Between tokens: this character may start a token or stand alone.
        if (do_idle) begin
            mode_next = M_IDLE;
            if (is_ws) begin
                mode_next = M_IDLE;
            end else if (c == tlt_pkg::CH_NUL) begin
                fin_next = 1'b1;
                b_vld    = 1'b1;
                b_kind   = tlt_pkg::KIND_END;
            end else if (punct_hit) begin
                b_vld  = 1'b1;
                b_kind = punct_kind;
                b_len  = 1'b1;
            end else if (c == tlt_pkg::CH_SLASH || c == tlt_pkg::CH_DOLLAR
                         || c == tlt_pkg::CH_QUOTE || is_alnum) begin
                pstart_next = pos_e;
                pline_next  = line_e;
                if (c == tlt_pkg::CH_SLASH) begin
                    mode_next = M_SLASH;
                end else if (c == tlt_pkg::CH_DOLLAR) begin
                    mode_next = M_DOLLAR;
                end else if (c == tlt_pkg::CH_QUOTE) begin
                    mode_next = M_QUOTE;
                end else begin
                    mode_next = M_IDENT;
                end
            end else begin
                fail = 1'b1;
            end
        end

        if (fail) begin
            fin_next  = 1'b1;
            mode_next = M_IDLE;
            b_vld     = 1'b1;
            b_kind    = tlt_pkg::KIND_ERR;
            b_len     = 1'b0;
        end

        pos_next  = (pos_e < CNT_MAX) ? pos_e + COUNT_BITS'(1) : pos_e;
        line_next = (c == tlt_pkg::CH_LF && line_e < CNT_MAX) ? line_e + COUNT_BITS'(1) : line_e;

        tok_a.token_kind   = a_kind;
        tok_a.token_start  = sat16(pstart_e);
        tok_a.token_length = sat16(a_len);
        tok_a.token_line   = sat16(pline_e);
        tok_a.run_last     = !b_vld;

        tok_b.token_kind   = b_kind;
        tok_b.token_start  = sat16(pos_e);
        tok_b.token_length = {15'd0, b_len};
        tok_b.token_line   = sat16(line_e);
        tok_b.run_last     = 1'b1;

        pair.count  = 2'(a_vld) + 2'(b_vld);
        pair.first  = a_vld ? tok_a : tok_b;
        pair.second = tok_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= M_IDLE;
            pos_reg    <= '0;
            line_reg   <= COUNT_BITS'(1);
            pstart_reg <= '0;
            pline_reg  <= COUNT_BITS'(1);
            fin_reg    <= 1'b0;
        end else if (step) begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            line_reg   <= line_next;
            pstart_reg <= pstart_next;
            pline_reg  <= pline_next;
            fin_reg    <= fin_next;
        end
    end

endmodule

// ===== design/tlt_result_fifo.sv =====
// Result queue: one entry per character that produced tokens, drained one token per cycle while m_ready is set.
module tlt_result_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  tlt_pkg::tok_pair_t  push_pair,
    output logic                has_room,
    output logic                m_valid,
    input  logic                m_ready,
    output tlt_pkg::out_item_t  m_data
);

    localparam int DEPTH    = tlt_pkg::RES_DEPTH;
    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    tlt_pkg::tok_pair_t  entry_reg [DEPTH];
    tlt_pkg::tok_pair_t  head;
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                phase_reg, phase_next;
    logic                pop, head_last;

    always_comb begin
        head      = entry_reg[rd_ptr_reg];
        has_room  = (cnt_reg != CNT_BITS'(DEPTH));
        m_valid   = (cnt_reg != '0);
        m_data    = phase_reg ? head.second : head.first;
        head_last = phase_reg || (head.count != 2'd2);
        pop       = m_valid && m_ready && head_last;

        phase_next = phase_reg;
        if (m_valid && m_ready) begin
            phase_next = !head_last;
        end

        wr_ptr_next = wr_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_BITS'(1);
        end
        rd_ptr_next = rd_ptr_reg;
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_BITS'(1);
        end

        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + CNT_BITS'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_pair;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            phase_reg  <= 1'b0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
            phase_reg  <= phase_next;
        end
    end

endmodule

// ===== design/tape_language_tokenizer_core.sv =====
// Top level of the tape language tokenizer: input register, lexer step and result queue.
//
// The core takes one source character per item and accepts a new item in every cycle
// while the result queue has room. A character is held in the input register, where
// the lexer applies its mode transition and forms the tokens it closes; these go into a
// four-entry result queue, from which the first token of a character can be taken once
// it is written there. Most characters close at most one token, so while the receiver is
// ready the sustained rate is one item per cycle. A character that ends an identifier or
// character variable and is itself a punctuator, an error or the end of input yields two
// tokens; the result channel moves one token per cycle while the receiver is ready, so
// such a character holds its queue entry until both tokens are taken and the input side
// stalls once the queue is full. After an end or error token nothing more is produced
// until an item arrives with start_new set; positions and line numbers keep advancing
// meanwhile, counting up to the limit of COUNT_BITS and reported saturated at 65535.
module tape_language_tokenizer_core #(
    parameter int COUNT_BITS = tlt_pkg::COUNT_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tlt_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output tlt_pkg::out_item_t m_data
);

    logic               in_valid_reg, in_valid_next;
    tlt_pkg::in_item_t  in_item_reg;
    logic               fifo_room;
    logic               step;
    logic               push;
    tlt_pkg::tok_pair_t pair;

    // The held character is processed as soon as the queue has an entry free.
    assign step    = in_valid_reg && fifo_room;
    assign push    = step && (pair.count != 2'd0);
    assign s_ready = !in_valid_reg || fifo_room;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // The item register itself needs no reset; its valid bit qualifies it.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
    end

    tlt_lexer #(
        .COUNT_BITS(COUNT_BITS)
    ) u_lexer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_item_reg),
        .pair    (pair)
    );

    tlt_result_fifo u_result_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_pair (pair),
        .has_room  (fifo_room),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // Every token kind the core produces lies within the defined range.
    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.token_kind <= tlt_pkg::KIND_MAX))
        else $error("token kind out of range");

    // End and error tokens carry no characters.
    a_marker_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.token_kind == tlt_pkg::KIND_END
                     || m_data.token_kind == tlt_pkg::KIND_ERR))
        |-> (m_data.token_length == 16'd0))
        else $error("end or error token with nonzero length");

    // Line numbers count from one.
    a_line_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.token_line != 16'd0))
        else $error("token line of zero");

    // A token that is not the last of its character is always followed by its partner.
    a_partner_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.run_last) |=> m_valid)
        else $error("second token of a character went missing");

endmodule
